// ===== rtl/dnc_pkg.sv =====
// ----------------------------------------------------------------------------
// dnc_pkg
// Shared types, character codes and helper functions for the delimiter
// nesting checker: scan modes, pending lookahead kinds and quote kinds.
// ----------------------------------------------------------------------------
package dnc_pkg;

  // Width of the reported depth field.
  localparam int OUT_DEPTH_W = 16;

  // Character codes that the scanner reacts to.
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Scan modes.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_STR1   = 3'd3,
    MODE_STR3   = 3'd4
  } scan_mode_t;

  // Pending lookahead kinds.
  typedef enum logic [2:0] {
    PEND_NONE  = 3'd0,
    PEND_DASH  = 3'd1,
    PEND_BRACE = 3'd2,
    PEND_QUOTE = 3'd3,
    PEND_BDASH = 3'd4
  } pend_kind_t;

  // Quote kinds.
  typedef enum logic [1:0] {
    QK_NONE   = 2'd0,
    QK_DQUOTE = 2'd1,
    QK_SQUOTE = 2'd2,
    QK_BQUOTE = 2'd3
  } quote_kind_t;

  // One input request.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_buffer;
  } item_t;

  // Report formed at the end of a buffer.
  typedef struct packed {
    logic                   needs_more;
    logic [OUT_DEPTH_W-1:0] open_depth;
    logic                   in_string_open;
    logic                   in_block_open;
  } report_t;

  // Map a byte to the quote kind that it opens, or none.
  function automatic quote_kind_t quote_code(input logic [7:0] b);
    quote_kind_t k;
    case (b)
      CH_DQUOTE: k = QK_DQUOTE;
      CH_SQUOTE: k = QK_SQUOTE;
      CH_BQUOTE: k = QK_BQUOTE;
      default:   k = QK_NONE;
    endcase
    return k;
  endfunction

  // True when the byte is the quote character of the given kind.
  function automatic logic quote_hit(input quote_kind_t kind, input logic [7:0] b);
    return (kind != QK_NONE) && (quote_code(b) == kind);
  endfunction

endpackage

// ===== rtl/delimiter_nesting_checker.sv =====
// ----------------------------------------------------------------------------
// delimiter_nesting_checker
// Checks whether a source text buffer is complete: bracket nesting, strings
// and block comments, fed one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one byte per request with
//   in_has_byte; in_end_of_buffer marks the last request of a buffer, which
//   may carry no byte. Only an end request produces a result on the output
//   channel (out_valid/out_ready): needs_more, open_depth (saturated to 16
//   bits), in_string_open and in_block_open.
//   Timing: a request is held in the input register, then scanned into the
//   scan state and, for an end request, into the result register, which
//   drives out_valid; an end request waits while an older result is unread.
//   Throughput: one request per cycle unless an end request waits on an
//   unread result; the scan step sits between input and scan state registers.
//   Stall: while a result waits unread, byte requests keep flowing; the next
//   end request holds in the input register until the result is taken.
//   Reset: synchronous, active low; the scan state returns to normal code,
//   depth zero, and both channels empty. After every end request the scan
//   state also returns to these values.
// ----------------------------------------------------------------------------
module delimiter_nesting_checker import dnc_pkg::*; #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_has_byte,
  input  logic                   in_end_of_buffer,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_needs_more,
  output logic [OUT_DEPTH_W-1:0] out_open_depth,
  output logic                   out_in_string_open,
  output logic                   out_in_block_open
);

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  report_t result_r;
  report_t report;
  logic    advance;

  // A byte request always advances; an end request needs a free result slot.
  assign advance  = in_valid_r && (!item_r.end_of_buffer || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{char_byte: in_char_byte, has_byte: in_has_byte,
                  end_of_buffer: in_end_of_buffer};
    end
  end

  // Scan state and next-state logic.
  dnc_scanner #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .report  (report)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item_r.end_of_buffer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_r.end_of_buffer) begin
      result_r <= report;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_needs_more     = result_r.needs_more;
  assign out_open_depth     = result_r.open_depth;
  assign out_in_string_open = result_r.in_string_open;
  assign out_in_block_open  = result_r.in_block_open;

  // An end request that advances always yields a result on the next cycle.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.end_of_buffer) |=> out_valid_r)
    else $error("end of buffer did not produce a result");

  // needs_more agrees with the other result fields.
  a_needs_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (result_r.needs_more ==
      ((result_r.open_depth != '0) || result_r.in_string_open || result_r.in_block_open)))
    else $error("needs_more inconsistent with result fields");

  // A string and a block comment are never open at the same time.
  a_exclusive_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(result_r.in_string_open && result_r.in_block_open))
    else $error("string and block comment both reported open");

endmodule

// ===== rtl/dnc_scanner.sv =====
// ----------------------------------------------------------------------------
// dnc_scanner
// Scan state registers and the per-byte next-state logic. One request is
// applied per cycle when step_en is high; an end request also forms the
// report and returns the state to its reset values.
// ----------------------------------------------------------------------------
module dnc_scanner import dnc_pkg::*; #(
  parameter int DEPTH_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output report_t report
);

  scan_mode_t            mode_r, mode_nxt;
  quote_kind_t           qkind_r, qkind_nxt;
  pend_kind_t            pend_r, pend_nxt;
  logic [1:0]            qrun_r, qrun_nxt;
  logic                  esc_r, esc_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [DEPTH_BITS-1:0] depth_end;
  logic [OUT_DEPTH_W-1:0] depth_clip;
  logic                  str_open, blk_open;

  function automatic logic [DEPTH_BITS-1:0] sat_inc(input logic [DEPTH_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [DEPTH_BITS-1:0] sat_dec(input logic [DEPTH_BITS-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Next scan state for one byte, then the end-of-buffer resolution.
  always_comb begin
    scan_mode_t            m;
    quote_kind_t           qk;
    pend_kind_t            pk;
    logic [1:0]            qr;
    logic                  esc;
    logic [DEPTH_BITS-1:0] d;
    logic                  done;
    logic [7:0]            b;

    m    = mode_r;
    qk   = qkind_r;
    pk   = pend_r;
    qr   = qrun_r;
    esc  = esc_r;
    d    = depth_r;
    done = 1'b0;
    b    = item.char_byte;

    if (item.has_byte) begin
      case (m)
        MODE_LINE: begin
          if (b == CH_NL) m = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (pk == PEND_BDASH && b == CH_RBRACE) begin
            m  = MODE_NORMAL;
            pk = PEND_NONE;
          end else begin
            pk = (b == CH_DASH) ? PEND_BDASH : PEND_NONE;
          end
        end
        MODE_STR1: begin
          if (esc) begin
            esc = 1'b0;
          end else if (b == CH_BSLASH) begin
            esc = 1'b1;
          end else if (quote_hit(qk, b) || b == CH_NL) begin
            m  = MODE_NORMAL;
            qk = QK_NONE;
          end
        end
        MODE_STR3: begin
          if (quote_hit(qk, b)) begin
            if (qr == 2'd2) begin
              qr = 2'd0;
              qk = QK_NONE;
              m  = MODE_NORMAL;
            end else begin
              qr = qr + 2'd1;
            end
          end else begin
            qr = 2'd0;
          end
        end
        default: begin
          // Normal code: first resolve any pending lookahead.
          m = MODE_NORMAL;
          case (pk)
            PEND_DASH: begin
              pk = PEND_NONE;
              if (b == CH_DASH) begin
                m    = MODE_LINE;
                done = 1'b1;
              end
            end
            PEND_BRACE: begin
              pk = PEND_NONE;
              if (b == CH_DASH) begin
                m    = MODE_BLOCK;
                done = 1'b1;
              end else begin
                d = sat_inc(d);
              end
            end
            PEND_QUOTE: begin
              if (qr == 2'd1) begin
                done = 1'b1;
                if (quote_hit(qk, b)) begin
                  qr = 2'd2;
                end else begin
                  // Single-quoted string starts; this byte is its first.
                  pk  = PEND_NONE;
                  qr  = 2'd0;
                  esc = 1'b0;
                  m   = MODE_STR1;
                  if (b == CH_BSLASH) begin
                    esc = 1'b1;
                  end else if (quote_hit(qk, b) || b == CH_NL) begin
                    m  = MODE_NORMAL;
                    qk = QK_NONE;
                  end
                end
              end else begin
                pk = PEND_NONE;
                qr = 2'd0;
                if (quote_hit(qk, b)) begin
                  m    = MODE_STR3;
                  done = 1'b1;
                end else begin
                  // Two quotes made an empty, closed string.
                  qk = QK_NONE;
                end
              end
            end
            default: pk = PEND_NONE;
          endcase

          // Then the byte itself.
          if (!done) begin
            if (b == CH_DASH) begin
              pk = PEND_DASH;
            end else if (b == CH_LBRACE) begin
              pk = PEND_BRACE;
            end else if (quote_code(b) != QK_NONE) begin
              pk = PEND_QUOTE;
              qk = quote_code(b);
              qr = 2'd1;
            end else if (b == CH_LPAREN || b == CH_LBRACK) begin
              d = sat_inc(d);
            end else if (b == CH_RPAREN || b == CH_RBRACK || b == CH_RBRACE) begin
              d = sat_dec(d);
            end
          end
        end
      endcase
    end

    // End of buffer: a lone pending brace counts as an opener.
    if (m == MODE_NORMAL && pk == PEND_BRACE) begin
      depth_end = sat_inc(d);
    end else begin
      depth_end = d;
    end
    str_open = (m == MODE_STR1) || (m == MODE_STR3) ||
               (m == MODE_NORMAL && pk == PEND_QUOTE && qr == 2'd1);
    blk_open = (m == MODE_BLOCK);

    if (item.end_of_buffer) begin
      mode_nxt  = MODE_NORMAL;
      qkind_nxt = QK_NONE;
      pend_nxt  = PEND_NONE;
      qrun_nxt  = 2'd0;
      esc_nxt   = 1'b0;
      depth_nxt = '0;
    end else begin
      mode_nxt  = m;
      qkind_nxt = qk;
      pend_nxt  = pk;
      qrun_nxt  = qr;
      esc_nxt   = esc;
      depth_nxt = d;
    end
  end

  // Clip the depth to the reported width.
  generate
    if (DEPTH_BITS > OUT_DEPTH_W) begin : g_clip
      assign depth_clip = (|depth_end[DEPTH_BITS-1:OUT_DEPTH_W]) ?
                          '1 : depth_end[OUT_DEPTH_W-1:0];
    end else begin : g_extend
      assign depth_clip = OUT_DEPTH_W'(depth_end);
    end
  endgenerate

  // Report fields.
  always_comb begin
    report.open_depth     = depth_clip;
    report.in_string_open = str_open;
    report.in_block_open  = blk_open;
    report.needs_more     = (depth_clip != '0) || str_open || blk_open;
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      qkind_r <= QK_NONE;
      pend_r  <= PEND_NONE;
      qrun_r  <= 2'd0;
      esc_r   <= 1'b0;
      depth_r <= '0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      qkind_r <= qkind_nxt;
      pend_r  <= pend_nxt;
      qrun_r  <= qrun_nxt;
      esc_r   <= esc_nxt;
      depth_r <= depth_nxt;
    end
  end

  // An end request leaves the scanner in its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item.end_of_buffer) |=>
      (mode_r == MODE_NORMAL && pend_r == PEND_NONE && depth_r == '0 && !esc_r))
    else $error("scan state not cleared after end of buffer");

  // An escape is only pending inside a single-quoted string.
  a_esc_in_str1: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (mode_r == MODE_STR1))
    else $error("escape pending outside a single-quoted string");

  // A quote run exists only while quotes are pending or in a triple string.
  a_qrun_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (qrun_r != 2'd0) |->
      ((mode_r == MODE_NORMAL && pend_r == PEND_QUOTE) || mode_r == MODE_STR3))
    else $error("quote run outside quote context");

endmodule

// ===== verif/dnc_checker.sv =====
// ----------------------------------------------------------------------------
// dnc_checker
// Watches both channels of the delimiter nesting checker, predicts the
// report for every end-of-buffer request and compares it field by field.
// ----------------------------------------------------------------------------
module dnc_checker import dnc_pkg::*; #(
  parameter int DEPTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_char_byte,
  input  logic                   in_has_byte,
  input  logic                   in_end_of_buffer,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_needs_more,
  input  logic [OUT_DEPTH_W-1:0] out_open_depth,
  input  logic                   out_in_string_open,
  input  logic                   out_in_block_open,
  output int unsigned            mismatches,
  output int unsigned            outstanding,
  output int unsigned            reports_checked,
  output int unsigned            bytes_scanned
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the scanner state.
  scan_mode_t            mode;
  pend_kind_t            pend;
  quote_kind_t           quote;
  logic [1:0]            qrun;
  logic                  esc;
  logic [DEPTH_BITS-1:0] depth;

  // Reports predicted but not yet seen on the result channel.
  report_t awaited_reports[$];

  int unsigned fail_tally;
  int unsigned report_tally;
  int unsigned byte_tally;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_tally++;
  endtask

  // True when the byte is the closing quote of the open string.
  function automatic logic closes_quote(input quote_kind_t k, input logic [7:0] b);
    case (k)
      QK_DQUOTE: return b == CH_DQUOTE;
      QK_SQUOTE: return b == CH_SQUOTE;
      QK_BQUOTE: return b == CH_BQUOTE;
      default:   return 1'b0;
    endcase
  endfunction

  // Quote kind that a byte opens in code.
  function automatic quote_kind_t opened_kind(input logic [7:0] b);
    if (b == CH_DQUOTE) return QK_DQUOTE;
    if (b == CH_SQUOTE) return QK_SQUOTE;
    if (b == CH_BQUOTE) return QK_BQUOTE;
    return QK_NONE;
  endfunction

  function void clear_scan();
    mode  = MODE_NORMAL;
    pend  = PEND_NONE;
    quote = QK_NONE;
    qrun  = 2'd0;
    esc   = 1'b0;
    depth = '0;
  endfunction

  // Depth saturates at its maximum.
  function void deepen();
    if (depth != '1) depth = depth + 1'b1;
  endfunction

  // Depth never drops below zero.
  function void shallow();
    if (depth != '0) depth = depth - 1'b1;
  endfunction

  // One byte inside a singly quoted string.
  function void string_byte(input logic [7:0] b);
    if (esc) begin
      esc = 1'b0;
    end else if (b == CH_BSLASH) begin
      esc = 1'b1;
    end else if (closes_quote(quote, b) || b == CH_NL) begin
      mode  = MODE_NORMAL;
      quote = QK_NONE;
    end
  endfunction

  // One byte in code: first settle any lookahead, then classify the byte.
  function void code_byte(input logic [7:0] b);
    logic done;
    done = 1'b0;
    case (pend)
      PEND_DASH: begin
        pend = PEND_NONE;
        if (b == CH_DASH) begin
          mode = MODE_LINE;
          done = 1'b1;
        end
      end
      PEND_BRACE: begin
        pend = PEND_NONE;
        if (b == CH_DASH) begin
          mode = MODE_BLOCK;
          done = 1'b1;
        end else begin
          deepen();
        end
      end
      PEND_QUOTE: begin
        if (qrun == 2'd1) begin
          // Second byte after an opening quote.
          if (closes_quote(quote, b)) begin
            qrun = 2'd2;
          end else begin
            pend = PEND_NONE;
            qrun = 2'd0;
            esc  = 1'b0;
            mode = MODE_STR1;
            string_byte(b);
          end
          done = 1'b1;
        end else begin
          // Two quotes seen: a third opens a long string, else it was empty.
          pend = PEND_NONE;
          qrun = 2'd0;
          if (closes_quote(quote, b)) begin
            mode = MODE_STR3;
            done = 1'b1;
          end else begin
            quote = QK_NONE;
          end
        end
      end
      default: pend = PEND_NONE;
    endcase
    if (!done) begin
      if (b == CH_DASH) begin
        pend = PEND_DASH;
      end else if (b == CH_LBRACE) begin
        pend = PEND_BRACE;
      end else if (opened_kind(b) != QK_NONE) begin
        pend  = PEND_QUOTE;
        quote = opened_kind(b);
        qrun  = 2'd1;
      end else if (b == CH_LPAREN || b == CH_LBRACK) begin
        deepen();
      end else if (b == CH_RPAREN || b == CH_RBRACK || b == CH_RBRACE) begin
        shallow();
      end
    end
  endfunction

  function void scan_byte(input logic [7:0] b);
    case (mode)
      MODE_NORMAL: code_byte(b);
      MODE_LINE: begin
        if (b == CH_NL) mode = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (pend == PEND_BDASH && b == CH_RBRACE) begin
          mode = MODE_NORMAL;
          pend = PEND_NONE;
        end else begin
          pend = (b == CH_DASH) ? PEND_BDASH : PEND_NONE;
        end
      end
      MODE_STR1: string_byte(b);
      MODE_STR3: begin
        if (closes_quote(quote, b)) begin
          if (qrun == 2'd2) begin
            qrun  = 2'd0;
            quote = QK_NONE;
            mode  = MODE_NORMAL;
          end else begin
            qrun = qrun + 2'd1;
          end
        end else begin
          qrun = 2'd0;
        end
      end
      default: begin
        mode = MODE_NORMAL;
        code_byte(b);
      end
    endcase
  endfunction

  // Resolve lookahead at the end of a buffer, form the report, start over.
  function report_t close_buffer();
    report_t r;
    logic    str_open;
    if (mode == MODE_NORMAL && pend == PEND_BRACE) deepen();
    str_open = (mode == MODE_STR1) || (mode == MODE_STR3) ||
               (mode == MODE_NORMAL && pend == PEND_QUOTE && qrun == 2'd1);
    if (DEPTH_BITS > OUT_DEPTH_W && (depth >> OUT_DEPTH_W) != 0) begin
      r.open_depth = '1;
    end else begin
      r.open_depth = OUT_DEPTH_W'(depth);
    end
    r.in_string_open = str_open;
    r.in_block_open  = (mode == MODE_BLOCK);
    r.needs_more     = (r.open_depth != '0) || str_open || r.in_block_open;
    clear_scan();
    return r;
  endfunction

  // Results are taken before requests so that a result can never be matched
  // against a report predicted at the same edge.
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      clear_scan();
      awaited_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          flag_mismatch("unexpected result", 1, 0);
        end else begin
          want = awaited_reports.pop_front();
          report_tally++;
          if (out_needs_more !== want.needs_more)
            flag_mismatch("needs_more", out_needs_more, want.needs_more);
          if (out_open_depth !== want.open_depth)
            flag_mismatch("open_depth", out_open_depth, want.open_depth);
          if (out_in_string_open !== want.in_string_open)
            flag_mismatch("in_string_open", out_in_string_open, want.in_string_open);
          if (out_in_block_open !== want.in_block_open)
            flag_mismatch("in_block_open", out_in_block_open, want.in_block_open);
        end
      end
      if (in_valid && in_ready) begin
        if (in_has_byte) begin
          scan_byte(in_char_byte);
          byte_tally++;
        end
        if (in_end_of_buffer) awaited_reports.push_back(close_buffer());
      end
    end
    mismatches      <= fail_tally;
    outstanding     <= awaited_reports.size();
    reports_checked <= report_tally;
    bytes_scanned   <= byte_tally;
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives source-text buffers into the delimiter nesting checker: a directed
// set of corner cases, then random buffers built from strings, comments,
// brackets and noise, with random stalls on both channels. The checker
// module predicts and compares.
// ----------------------------------------------------------------------------
module testbench import dnc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_BITS     = 16;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int CALM_AFTER     = 950;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 400000;

  logic                   clk                = 1'b0;
  logic                   rst_n              = 1'b0;
  logic                   in_valid           = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_char_byte       = 8'h00;
  logic                   in_has_byte        = 1'b0;
  logic                   in_end_of_buffer   = 1'b0;
  logic                   out_valid;
  logic                   out_ready          = 1'b0;
  logic                   out_needs_more;
  logic [OUT_DEPTH_W-1:0] out_open_depth;
  logic                   out_in_string_open;
  logic                   out_in_block_open;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned reports_checked;
  int unsigned bytes_scanned;

  bit          gaps_on = 1'b1;
  int unsigned items_sent;
  int unsigned buffers_sent;
  int unsigned cycle_count;
  logic [7:0]  text[$];

  delimiter_nesting_checker #(.DEPTH_BITS(DEPTH_BITS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_byte       (in_char_byte),
    .in_has_byte        (in_has_byte),
    .in_end_of_buffer   (in_end_of_buffer),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_needs_more     (out_needs_more),
    .out_open_depth     (out_open_depth),
    .out_in_string_open (out_in_string_open),
    .out_in_block_open  (out_in_block_open)
  );

  dnc_checker #(.DEPTH_BITS(DEPTH_BITS)) scoreboard (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_byte       (in_char_byte),
    .in_has_byte        (in_has_byte),
    .in_end_of_buffer   (in_end_of_buffer),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_needs_more     (out_needs_more),
    .out_open_depth     (out_open_depth),
    .out_in_string_open (out_in_string_open),
    .out_in_block_open  (out_in_block_open),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .reports_checked    (reports_checked),
    .bytes_scanned      (bytes_scanned)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: random stall bursts while gaps are enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped after %0d cycles with %0d reports outstanding",
             cycle_count, outstanding);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Send one request, with an optional idle burst first, and wait for it.
  task automatic send_item(input logic [7:0] b, input logic has, input logic eob);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_char_byte     <= b;
    in_has_byte      <= has;
    in_end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    if (has || eob) items_sent++;
    if (eob) buffers_sent++;
  endtask

  // Send the bytes held in text as one buffer. The end mark rides on the last
  // byte, or on a separate request without a byte.
  task automatic send_buffer(input bit empty_end, input bit with_idles);
    for (int i = 0; i < text.size(); i++) begin
      if (with_idles && $urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(text[i], 1'b1, !empty_end && i == text.size() - 1);
    end
    if (empty_end || text.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] any_quote();
    case ($urandom_range(0, 2))
      0:       return CH_DQUOTE;
      1:       return CH_SQUOTE;
      default: return CH_BQUOTE;
    endcase
  endfunction

  function automatic logic [7:0] any_opener();
    case ($urandom_range(0, 2))
      0:       return CH_LPAREN;
      1:       return CH_LBRACK;
      default: return CH_LBRACE;
    endcase
  endfunction

  function automatic logic [7:0] any_closer();
    case ($urandom_range(0, 2))
      0:       return CH_RPAREN;
      1:       return CH_RBRACK;
      default: return CH_RBRACE;
    endcase
  endfunction

  // Weighted content byte: letters most often, with every special byte likely.
  function automatic logic [7:0] soup_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return any_opener();
    if (roll < 20) return any_closer();
    if (roll < 28) return CH_DASH;
    if (roll < 36) return any_quote();
    if (roll < 40) return CH_BSLASH;
    if (roll < 45) return CH_NL;
    if (roll < 85) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  // Append one mostly well-formed construct to text.
  task automatic add_fragment();
    logic [7:0] q;
    int         n;
    q = any_quote();
    case ($urandom_range(0, 6))
      0: repeat ($urandom_range(1, 4)) text.push_back(soup_byte());
      1: begin
        // Short string with escapes, closed by its quote or a newline, or left open.
        text.push_back(q);
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 3) == 0) begin
            text.push_back(CH_BSLASH);
            text.push_back($urandom_range(0, 2) == 0 ? q : soup_byte());
          end else begin
            text.push_back(soup_byte());
          end
        end
        case ($urandom_range(0, 5))
          0: text.push_back(CH_NL);
          1: begin
            // Left open.
          end
          default: text.push_back(q);
        endcase
      end
      2: begin
        // Long string, with random quotes inside; sometimes left open.
        repeat (3) text.push_back(q);
        repeat ($urandom_range(0, 4)) text.push_back($urandom_range(0, 2) == 0 ? q : soup_byte());
        if ($urandom_range(0, 4) != 0) repeat (3) text.push_back(q);
      end
      3: begin
        text.push_back(CH_DASH);
        text.push_back(CH_DASH);
        repeat ($urandom_range(0, 4)) text.push_back(soup_byte());
        if ($urandom_range(0, 4) != 0) text.push_back(CH_NL);
      end
      4: begin
        text.push_back(CH_LBRACE);
        text.push_back(CH_DASH);
        repeat ($urandom_range(0, 5)) text.push_back(soup_byte());
        if ($urandom_range(0, 4) != 0) begin
          text.push_back(CH_DASH);
          text.push_back(CH_RBRACE);
        end
      end
      5: begin
        n = $urandom_range(1, 3);
        repeat (n) text.push_back(any_opener());
        repeat ($urandom_range(0, 3)) text.push_back(soup_byte());
        repeat ($urandom_range(0, n + 1)) text.push_back(any_closer());
      end
      default: begin
        // Empty string, sometimes directly followed by more code.
        text.push_back(q);
        text.push_back(q);
        if ($urandom_range(0, 1) == 0) text.push_back(soup_byte());
      end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    items_sent   = 0;
    buffers_sent = 0;

    // Directed corner cases.
    text.delete();
    send_buffer(1'b1, 1'b0);                       // empty end request alone
    send_item(8'hA5, 1'b0, 1'b0);                  // no byte and no end: ignored
    text = '{8'h00, 8'hFF};
    send_buffer(1'b0, 1'b0);                       // zero byte and top byte
    text = '{CH_DASH};
    send_buffer(1'b0, 1'b0);                       // lone dash at the end
    text = '{CH_LBRACE};
    send_buffer(1'b1, 1'b0);                       // lone brace counts as open
    text = '{CH_DQUOTE};
    send_buffer(1'b0, 1'b0);                       // one quote leaves a string open
    text = '{CH_SQUOTE, CH_SQUOTE};
    send_buffer(1'b0, 1'b0);                       // two quotes: empty string
    text = '{CH_BQUOTE, CH_BSLASH};
    send_buffer(1'b0, 1'b0);                       // escape as last byte
    text = '{CH_RPAREN, CH_RBRACK, CH_LPAREN};
    send_buffer(1'b0, 1'b0);                       // closers at depth zero
    text = '{CH_LBRACE, CH_DASH};
    send_buffer(1'b0, 1'b0);                       // block comment left open
    text = '{CH_DASH, CH_DASH};
    send_buffer(1'b0, 1'b0);                       // line comment is not open
    text = '{CH_DQUOTE, CH_DQUOTE, CH_DQUOTE};
    send_buffer(1'b0, 1'b0);                       // long string left open

    // Random buffers; the last stretch runs without stalls.
    gaps_on    = 1'b1;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > CALM_AFTER) gaps_on = 1'b0;
      text.delete();
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) add_fragment();
      end
      send_buffer($urandom_range(0, 2) == 0, 1'b1);
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline before the verdict.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d buffers and %0d scanned bytes; %0d reports compared.",
             buffers_sent, bytes_scanned, reports_checked);
    $display("Included corner cases, empty end requests and random stalls on both sides.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
